// ----- rtl/sll_pkg.sv -----
`default_nettype none

package sll_pkg;

  localparam int IDENT_BUF_DEF = 32;
  localparam int KW_COUNT      = 12;
  localparam int KW_MAX_LEN    = 5;

  localparam logic [30:0] LIT_MAX  = 31'h7FFF_FFFF;
  localparam logic [23:0] LINE_MAX = 24'hFF_FFFF;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [5:0] TK_EOF         = 6'd0;
  localparam logic [5:0] TK_PLUS        = 6'd1;
  localparam logic [5:0] TK_MINUS       = 6'd2;
  localparam logic [5:0] TK_STAR        = 6'd3;
  localparam logic [5:0] TK_SLASH       = 6'd4;
  localparam logic [5:0] TK_SEMI        = 6'd5;
  localparam logic [5:0] TK_ASSIGN      = 6'd6;
  localparam logic [5:0] TK_EQEQ        = 6'd7;
  localparam logic [5:0] TK_NE          = 6'd8;
  localparam logic [5:0] TK_LT          = 6'd9;
  localparam logic [5:0] TK_LE          = 6'd10;
  localparam logic [5:0] TK_GT          = 6'd11;
  localparam logic [5:0] TK_GE          = 6'd12;
  localparam logic [5:0] TK_COLON       = 6'd13;
  localparam logic [5:0] TK_LBRACE      = 6'd14;
  localparam logic [5:0] TK_RBRACE      = 6'd15;
  localparam logic [5:0] TK_LPAREN      = 6'd16;
  localparam logic [5:0] TK_RPAREN      = 6'd17;
  localparam logic [5:0] TK_INTLIT      = 6'd18;
  localparam logic [5:0] TK_IDENT       = 6'd19;
  localparam logic [5:0] TK_ELSE        = 6'd20;
  localparam logic [5:0] TK_ICHAR       = 6'd32;
  localparam logic [5:0] TK_ERR_UNKNOWN = 6'd33;
  localparam logic [5:0] TK_ERR_BANG    = 6'd34;
  localparam logic [5:0] TK_ERR_LONG    = 6'd35;

  // Keywords in token order, starting at TK_ELSE; unused tail bytes are zero.
  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
    '{"e", "l", "s", "e", 8'h00},
    '{"f", "o", "r", 8'h00, 8'h00},
    '{"f", "u", "n", "c", 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00},
    '{"i", "3", "2", 8'h00, 8'h00},
    '{"i", "6", "4", 8'h00, 8'h00},
    '{"l", "e", "t", 8'h00, 8'h00},
    '{"p", "r", "i", "n", "t"},
    '{"r", "e", "t", 8'h00, 8'h00},
    '{"u", "0", 8'h00, 8'h00, 8'h00},
    '{"u", "8", 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e"}
  };

  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd4, 3'd3, 3'd4, 3'd2, 3'd3, 3'd3, 3'd3, 3'd5, 3'd3, 3'd2, 3'd2, 3'd5
  };

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } sll_in_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [30:0] int_value;
    logic [5:0]  ident_len;
    logic [7:0]  char_value;
    logic [23:0] line_number;
    logic        last;
  } sll_out_t;

  typedef enum logic [2:0] {
    MD_IDLE, MD_EQ, MD_LT, MD_GT, MD_BANG, MD_INT, MD_IDENT, MD_ERR
  } scan_mode_t;

  typedef enum logic [2:0] {
    ST_READY, ST_FLUSH, ST_CHARS, ST_SCAN, ST_EOF
  } ctrl_state_t;

  typedef struct packed {
    logic       take;
    logic       emit;
    logic [5:0] emit_kind;
    logic       emit_last;
    logic       acc_step;
    logic       acc_load;
    logic       acc_clear;
    logic       id_start;
    logic       id_push;
    logic       id_clear;
    logic       idx_clear;
    logic       idx_step;
  } sll_cmd_t;

  typedef struct packed {
    logic       eoi;
    logic       is_ws;
    logic       is_digit;
    logic       is_ident;
    logic       is_eq;
    logic       is_lt;
    logic       is_gt;
    logic       is_bang;
    logic       is_op;
    logic [5:0] op_kind;
    logic       count_full;
    logic       kw_hit;
    logic [5:0] kw_kind;
    logic       last_char;
    logic       slot_free;
  } sll_stat_t;

  function automatic logic [7:0] kw_char(logic [3:0] k, logic [5:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    if (pos < 6'(KW_MAX_LEN)) ch = KW_TEXT[k][pos[2:0]];
    return ch;
  endfunction

  // Single-byte operators; TK_EOF for anything else.
  function automatic logic [5:0] op_kind_of(logic [7:0] c);
    logic [5:0] k;
    case (c)
      "+":     k = TK_PLUS;
      "-":     k = TK_MINUS;
      "*":     k = TK_STAR;
      "/":     k = TK_SLASH;
      ";":     k = TK_SEMI;
      ":":     k = TK_COLON;
      "{":     k = TK_LBRACE;
      "}":     k = TK_RBRACE;
      "(":     k = TK_LPAREN;
      ")":     k = TK_RPAREN;
      default: k = TK_EOF;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/small_language_lexer.sv -----
`default_nettype none

// Channel   Direction  Handshake                Payload
// char      in         char_valid / char_stall  sll_in_t  (char_code, end_of_input)
// tok       out        tok_valid / tok_stall    sll_out_t (token_kind .. last)
//
// A byte that yields no token (inside a literal or identifier, whitespace)
// leaves the lexer ready. After a byte that yields tokens, char_stall
// holds while they go out one at a time through the output register, longer
// while tok_stall holds; identifier characters are read back from the
// buffer one per cycle unless tok_stall holds. Reset clears the scanner
// state and sets the line count to 1; the identifier buffer is not cleared.

module small_language_lexer import sll_pkg::*; #(
  parameter int IDENT_BUF = IDENT_BUF_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    char_valid,
  output logic         char_stall,
  input  wire sll_in_t char_item,
  output logic         tok_valid,
  input  wire logic    tok_stall,
  output sll_out_t     tok_item
);

  sll_cmd_t  cmd;
  sll_stat_t stat;
  logic      at_ready;

  sll_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .at_ready   (at_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  sll_dp #(
    .IDENT_BUF (IDENT_BUF)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .char_item (char_item),
    .at_ready  (at_ready),
    .cmd       (cmd),
    .stat      (stat),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_item  (tok_item)
  );

endmodule

`default_nettype wire

// ----- rtl/sll_dp.sv -----
`default_nettype none

module sll_dp import sll_pkg::*; #(
  parameter int IDENT_BUF = IDENT_BUF_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire sll_in_t   char_item,
  input  wire logic      at_ready,
  input  wire sll_cmd_t  cmd,
  output sll_stat_t      stat,
  output logic           tok_valid,
  input  wire logic      tok_stall,
  output sll_out_t       tok_item
);

  localparam int AW = $clog2(IDENT_BUF);
  localparam logic [AW-1:0] CNT_MAX = AW'(IDENT_BUF - 1);

  logic [7:0]          char_q;
  logic                eoi_q;
  logic [7:0]          cur_char;
  logic                cur_eoi;
  logic [30:0]         accum;
  logic [34:0]         acc_sum;
  logic [30:0]         acc_sat;
  logic [23:0]         line_count;
  logic [AW-1:0]       count;
  logic [AW-1:0]       idx;
  logic [AW-1:0]       idx_next;
  logic [AW-1:0]       waddr;
  logic [7:0]          rd_data;
  logic [KW_COUNT-1:0] match;
  logic [7:0]          store_mem [IDENT_BUF];
  sll_out_t            out_next;

  assign cur_char = at_ready ? char_item.char_code : char_q;
  assign cur_eoi  = at_ready ? char_item.end_of_input : eoi_q;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      char_q <= char_item.char_code;
      eoi_q  <= char_item.end_of_input;
    end
  end

  // Character classes of the current byte.
  always_comb begin
    stat.eoi      = cur_eoi;
    stat.is_ws    = cur_char == CH_SPACE || cur_char == CH_TAB || cur_char == CH_NL ||
                    cur_char == CH_CR || cur_char == CH_FF;
    stat.is_digit = cur_char >= "0" && cur_char <= "9";
    stat.is_ident = stat.is_digit || cur_char == "_" ||
                    (cur_char >= "a" && cur_char <= "z") ||
                    (cur_char >= "A" && cur_char <= "Z");
    stat.is_eq    = cur_char == "=";
    stat.is_lt    = cur_char == "<";
    stat.is_gt    = cur_char == ">";
    stat.is_bang  = cur_char == "!";
    stat.op_kind  = op_kind_of(cur_char);
    stat.is_op    = stat.op_kind != TK_EOF;
    stat.count_full = count >= CNT_MAX;
    stat.last_char  = idx == AW'(count - 1'b1);
    stat.slot_free  = !tok_valid || !tok_stall;

    stat.kw_hit  = 1'b0;
    stat.kw_kind = TK_EOF;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (match[k] && 6'(count) == 6'(KW_LEN[k])) begin
        stat.kw_hit  = 1'b1;
        stat.kw_kind = TK_ELSE + 6'(k);
      end
    end
  end

  // Literal: accum * 10 + digit, saturate.
  always_comb begin
    acc_sum = 35'({accum, 3'b000}) + 35'({accum, 1'b0}) + 35'(4'(cur_char - "0"));
    acc_sat = (acc_sum > 35'(LIT_MAX)) ? LIT_MAX : acc_sum[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum      <= '0;
      count      <= '0;
      line_count <= 24'd1;
    end else begin
      if (cmd.acc_load)       accum <= 31'(cur_char - "0");
      else if (cmd.acc_step)  accum <= acc_sat;
      else if (cmd.acc_clear) accum <= '0;

      if (cmd.id_start)      count <= AW'(1);
      else if (cmd.id_push)  count <= count + 1'b1;
      else if (cmd.id_clear) count <= '0;

      if (cmd.take && !char_item.end_of_input && char_item.char_code == CH_NL &&
          line_count != LINE_MAX) begin
        line_count <= line_count + 1'b1;
      end
    end
  end

  // Track which keywords the identifier still matches, one byte at a time.
  always_ff @(posedge clk) begin
    for (int k = 0; k < KW_COUNT; k++) begin
      if (cmd.id_start) begin
        match[k] <= cur_char == kw_char(4'(k), 6'd0);
      end else if (cmd.id_push) begin
        match[k] <= match[k] && cur_char == kw_char(4'(k), 6'(count));
      end
    end
  end

  assign waddr    = cmd.id_start ? '0 : count;
  assign idx_next = cmd.idx_clear ? '0 : (cmd.idx_step ? idx + 1'b1 : idx);

  always_ff @(posedge clk) begin
    if (cmd.id_start || cmd.id_push) store_mem[waddr] <= cur_char;
    rd_data <= store_mem[idx_next];
    idx     <= idx_next;
  end

  always_comb begin
    out_next.token_kind  = cmd.emit_kind;
    out_next.int_value   = '0;
    out_next.ident_len   = '0;
    out_next.char_value  = '0;
    out_next.line_number = line_count;
    out_next.last        = cmd.emit_last;
    case (cmd.emit_kind) inside
      TK_INTLIT: out_next.int_value  = accum;
      TK_IDENT:  out_next.ident_len  = 6'(count);
      TK_ICHAR:  out_next.char_value = rd_data;
      TK_ERR_UNKNOWN, TK_ERR_BANG, TK_ERR_LONG:
        out_next.char_value = cur_eoi ? 8'h00 : cur_char;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (cmd.emit) begin
      tok_valid <= 1'b1;
    end else if (!tok_stall) begin
      tok_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) tok_item <= out_next;
  end

endmodule

`default_nettype wire

// ----- rtl/sll_ctrl.sv -----
`default_nettype none

module sll_ctrl import sll_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      char_valid,
  output logic           char_stall,
  output logic           at_ready,
  input  wire sll_stat_t stat,
  output sll_cmd_t       cmd
);

  ctrl_state_t state, state_next;
  scan_mode_t  mode, mode_next;

  logic        unknown;
  logic        has_res;
  logic        tail_last;
  ctrl_state_t tail_state;
  scan_mode_t  tail_mode;
  scan_mode_t  idle_mode;
  logic        pair;
  logic [5:0]  pair_kind;
  logic [5:0]  single_kind;

  // Rescan of the current byte from idle once a pending token is out.
  function automatic sll_cmd_t with_tail(sll_cmd_t c, sll_stat_t s, logic res);
    sll_cmd_t r;
    r = c;
    if (!s.eoi && !res) begin
      r.acc_load = s.is_digit;
      r.id_start = s.is_ident && !s.is_digit;
    end
    return r;
  endfunction

  always_comb begin
    unknown = !(stat.is_ws || stat.is_op || stat.is_eq || stat.is_lt || stat.is_gt ||
                stat.is_bang || stat.is_ident);
    has_res   = stat.is_op || unknown;
    tail_last = !stat.eoi && !has_res;
    pair      = !stat.eoi && stat.is_eq;

    if (stat.is_eq)         idle_mode = MD_EQ;
    else if (stat.is_lt)    idle_mode = MD_LT;
    else if (stat.is_gt)    idle_mode = MD_GT;
    else if (stat.is_bang)  idle_mode = MD_BANG;
    else if (stat.is_digit) idle_mode = MD_INT;
    else if (stat.is_ident) idle_mode = MD_IDENT;
    else                    idle_mode = MD_IDLE;

    if (stat.eoi)     tail_state = ST_EOF;
    else if (has_res) tail_state = ST_SCAN;
    else              tail_state = ST_READY;
    tail_mode = (stat.eoi || has_res) ? MD_IDLE : idle_mode;

    unique case (mode)
      MD_LT: begin
        pair_kind   = TK_LE;
        single_kind = TK_LT;
      end
      MD_GT: begin
        pair_kind   = TK_GE;
        single_kind = TK_GT;
      end
      default: begin
        pair_kind   = TK_EQEQ;
        single_kind = TK_ASSIGN;
      end
    endcase
  end

  assign at_ready   = state == ST_READY;
  assign char_stall = state != ST_READY;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_READY;
      mode  <= MD_IDLE;
    end else begin
      state <= state_next;
      mode  <= mode_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    mode_next  = mode;
    unique case (state)
      ST_READY: begin
        if (char_valid) begin
          if (stat.eoi) begin
            if (mode == MD_IDLE)     state_next = ST_EOF;
            else if (mode != MD_ERR) state_next = ST_FLUSH;
          end else begin
            unique case (mode)
              MD_ERR: begin
              end
              MD_IDLE: begin
                state_next = tail_state;
                mode_next  = tail_mode;
              end
              MD_INT: begin
                if (!stat.is_digit) state_next = ST_FLUSH;
              end
              MD_IDENT: begin
                if (!stat.is_ident || stat.count_full) state_next = ST_FLUSH;
              end
              default: state_next = ST_FLUSH;
            endcase
          end
        end
      end
      ST_FLUSH: begin
        if (stat.slot_free) begin
          unique case (mode)
            MD_EQ, MD_LT, MD_GT: begin
              if (pair) begin
                state_next = ST_READY;
                mode_next  = MD_IDLE;
              end else begin
                state_next = tail_state;
                mode_next  = tail_mode;
              end
            end
            MD_BANG: begin
              state_next = ST_READY;
              mode_next  = pair ? MD_IDLE : MD_ERR;
            end
            MD_INT: begin
              state_next = tail_state;
              mode_next  = tail_mode;
            end
            MD_IDENT: begin
              if (!stat.eoi && stat.is_ident) begin
                state_next = ST_READY;
                mode_next  = MD_ERR;
              end else if (stat.kw_hit) begin
                state_next = tail_state;
                mode_next  = tail_mode;
              end else begin
                state_next = ST_CHARS;
              end
            end
            default: state_next = ST_READY;
          endcase
        end
      end
      ST_CHARS: begin
        if (stat.slot_free && stat.last_char) begin
          state_next = tail_state;
          mode_next  = tail_mode;
        end
      end
      ST_SCAN: begin
        if (stat.slot_free) begin
          state_next = ST_READY;
          mode_next  = stat.is_op ? MD_IDLE : MD_ERR;
        end
      end
      ST_EOF: begin
        if (stat.slot_free) begin
          state_next = ST_READY;
          mode_next  = MD_IDLE;
        end
      end
      default: state_next = ST_READY;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    cmd.take = at_ready && char_valid;
    unique case (state)
      ST_READY: begin
        if (char_valid && !stat.eoi) begin
          unique case (mode)
            MD_IDLE:  cmd = with_tail(cmd, stat, has_res);
            MD_INT:   cmd.acc_step = stat.is_digit;
            MD_IDENT: cmd.id_push  = stat.is_ident && !stat.count_full;
            default: ;
          endcase
        end
      end
      ST_FLUSH: begin
        if (stat.slot_free) begin
          cmd.emit = 1'b1;
          unique case (mode)
            MD_EQ, MD_LT, MD_GT: begin
              if (pair) begin
                cmd.emit_kind = pair_kind;
                cmd.emit_last = 1'b1;
              end else begin
                cmd.emit_kind = single_kind;
                cmd.emit_last = tail_last;
                cmd = with_tail(cmd, stat, has_res);
              end
            end
            MD_BANG: begin
              cmd.emit_kind = pair ? TK_NE : TK_ERR_BANG;
              cmd.emit_last = 1'b1;
            end
            MD_INT: begin
              cmd.emit_kind = TK_INTLIT;
              cmd.emit_last = tail_last;
              cmd.acc_clear = 1'b1;
              cmd = with_tail(cmd, stat, has_res);
            end
            MD_IDENT: begin
              if (!stat.eoi && stat.is_ident) begin
                cmd.emit_kind = TK_ERR_LONG;
                cmd.emit_last = 1'b1;
              end else if (stat.kw_hit) begin
                cmd.emit_kind = stat.kw_kind;
                cmd.emit_last = tail_last;
                cmd.id_clear  = 1'b1;
                cmd = with_tail(cmd, stat, has_res);
              end else begin
                cmd.emit_kind = TK_IDENT;
                cmd.idx_clear = 1'b1;
              end
            end
            default: cmd.emit = 1'b0;
          endcase
        end
      end
      ST_CHARS: begin
        if (stat.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = TK_ICHAR;
          cmd.idx_step  = 1'b1;
          if (stat.last_char) begin
            cmd.emit_last = tail_last;
            cmd.id_clear  = 1'b1;
            cmd = with_tail(cmd, stat, has_res);
          end
        end
      end
      ST_SCAN: begin
        if (stat.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = stat.is_op ? stat.op_kind : TK_ERR_UNKNOWN;
          cmd.emit_last = 1'b1;
        end
      end
      ST_EOF: begin
        if (stat.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = TK_EOF;
          cmd.emit_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- bench/sll_token_checker.sv -----
module sll_token_checker import sll_pkg::*; #(
  parameter int IDENT_BUF = IDENT_BUF_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     char_valid,
  input  wire logic     char_stall,
  input  wire sll_in_t  char_item,
  input  wire logic     tok_valid,
  input  wire logic     tok_stall,
  input  wire sll_out_t tok_item,
  output int            fail_count,
  output int            pending,
  output int            tokens_checked
);

  timeunit 1ns;
  timeprecision 1ps;

  scan_mode_t  mode;
  logic [30:0] lit_acc;
  logic [7:0]  id_buf [IDENT_BUF];
  int unsigned id_len;
  logic [23:0] line_no;
  int          step_tokens;
  sll_out_t    expected_tokens [$];

  int mismatches = 0;
  int waiting = 0;
  int matched = 0;

  assign fail_count = mismatches;
  assign pending = waiting;
  assign tokens_checked = matched;

  function automatic string keyword_spelling(int k);
    case (k)
      0:       return "else";
      1:       return "for";
      2:       return "func";
      3:       return "if";
      4:       return "i32";
      5:       return "i64";
      6:       return "let";
      7:       return "print";
      8:       return "ret";
      9:       return "u0";
      10:      return "u8";
      default: return "while";
    endcase
  endfunction

  function automatic bit is_digit_ch(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_word_ch(logic [7:0] c);
    return is_digit_ch(c) || c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function void emit(logic [5:0] kind, logic [30:0] ival, logic [5:0] len, logic [7:0] ch);
    sll_out_t t;
    t.token_kind  = kind;
    t.int_value   = ival;
    t.ident_len   = len;
    t.char_value  = ch;
    t.line_number = line_no;
    t.last        = 1'b0;
    expected_tokens.push_back(t);
    step_tokens++;
  endfunction

  // Keyword match first; a plain name is followed by its spelling, one item per char.
  function void flush_word();
    string kw;
    int    hit;
    bit    same;
    hit = -1;
    for (int k = 0; k < KW_COUNT; k++) begin
      kw = keyword_spelling(k);
      if (hit < 0 && kw.len() == id_len) begin
        same = 1'b1;
        for (int i = 0; i < kw.len(); i++) begin
          if (kw[i] != id_buf[i]) same = 1'b0;
        end
        if (same) hit = k;
      end
    end
    if (hit >= 0) begin
      emit(TK_ELSE + 6'(hit), 0, 0, 0);
    end else begin
      emit(TK_IDENT, 0, 6'(id_len), 0);
      for (int i = 0; i < id_len; i++) emit(TK_ICHAR, 0, 0, id_buf[i]);
    end
    id_len = 0;
  endfunction

  function void lex_fresh(logic [7:0] c);
    mode = MD_IDLE;
    case (c)
      CH_SPACE, CH_TAB, CH_NL, CH_CR, CH_FF: ;
      "+": emit(TK_PLUS, 0, 0, 0);
      "-": emit(TK_MINUS, 0, 0, 0);
      "*": emit(TK_STAR, 0, 0, 0);
      "/": emit(TK_SLASH, 0, 0, 0);
      ";": emit(TK_SEMI, 0, 0, 0);
      ":": emit(TK_COLON, 0, 0, 0);
      "{": emit(TK_LBRACE, 0, 0, 0);
      "}": emit(TK_RBRACE, 0, 0, 0);
      "(": emit(TK_LPAREN, 0, 0, 0);
      ")": emit(TK_RPAREN, 0, 0, 0);
      "=": mode = MD_EQ;
      "<": mode = MD_LT;
      ">": mode = MD_GT;
      "!": mode = MD_BANG;
      default: begin
        if (is_digit_ch(c)) begin
          lit_acc = 31'(c - "0");
          mode = MD_INT;
        end else if (is_word_ch(c)) begin
          id_buf[0] = c;
          id_len = 1;
          mode = MD_IDENT;
        end else begin
          emit(TK_ERR_UNKNOWN, 0, 0, c);
          mode = MD_ERR;
        end
      end
    endcase
  endfunction

  // Resolve a one-char operator that may pair with a following '='.
  function void lex_pair(logic [7:0] c, logic [5:0] with_eq, logic [5:0] alone);
    if (c == "=") begin
      emit(with_eq, 0, 0, 0);
      mode = MD_IDLE;
    end else begin
      emit(alone, 0, 0, 0);
      lex_fresh(c);
    end
  endfunction

  function void lex_byte(logic [7:0] c);
    longint unsigned wide;
    case (mode)
      MD_EQ: lex_pair(c, TK_EQEQ, TK_ASSIGN);
      MD_LT: lex_pair(c, TK_LE, TK_LT);
      MD_GT: lex_pair(c, TK_GE, TK_GT);
      MD_BANG: begin
        if (c == "=") begin
          emit(TK_NE, 0, 0, 0);
          mode = MD_IDLE;
        end else begin
          emit(TK_ERR_BANG, 0, 0, c);
          mode = MD_ERR;
        end
      end
      MD_INT: begin
        if (is_digit_ch(c)) begin
          wide = 64'(lit_acc) * 64'd10 + 64'(c) - 64'd48;
          lit_acc = (wide > 64'(LIT_MAX)) ? LIT_MAX : 31'(wide);
        end else begin
          emit(TK_INTLIT, lit_acc, 0, 0);
          lit_acc = '0;
          lex_fresh(c);
        end
      end
      MD_IDENT: begin
        if (is_word_ch(c)) begin
          if (id_len >= IDENT_BUF - 1) begin
            emit(TK_ERR_LONG, 0, 0, c);
            mode = MD_ERR;
          end else begin
            id_buf[id_len] = c;
            id_len++;
          end
        end else begin
          flush_word();
          lex_fresh(c);
        end
      end
      MD_ERR: ;
      default: lex_fresh(c);
    endcase
  endfunction

  function void lex_end();
    if (mode == MD_BANG) begin
      emit(TK_ERR_BANG, 0, 0, 0);
      mode = MD_ERR;
    end else if (mode != MD_ERR) begin
      case (mode)
        MD_EQ: emit(TK_ASSIGN, 0, 0, 0);
        MD_LT: emit(TK_LT, 0, 0, 0);
        MD_GT: emit(TK_GT, 0, 0, 0);
        MD_INT: begin
          emit(TK_INTLIT, lit_acc, 0, 0);
          lit_acc = '0;
        end
        MD_IDENT: flush_word();
        default: ;
      endcase
      emit(TK_EOF, 0, 0, 0);
      mode = MD_IDLE;
    end
  endfunction

  function void predict_tokens(sll_in_t it);
    sll_out_t t;
    step_tokens = 0;
    if (it.end_of_input) begin
      lex_end();
    end else begin
      // Newline counts before any token it completes.
      if (it.char_code == CH_NL && line_no < LINE_MAX) line_no++;
      lex_byte(it.char_code);
    end
    if (step_tokens > 0) begin
      t = expected_tokens.pop_back();
      t.last = 1'b1;
      expected_tokens.push_back(t);
    end
  endfunction

  function void check_token(sll_out_t got);
    sll_out_t want;
    if (expected_tokens.size() == 0) begin
      $error("unexpected token: kind %0d line %0d", got.token_kind, got.line_number);
      mismatches++;
    end else begin
      want = expected_tokens.pop_front();
      matched++;
      if (got.token_kind !== want.token_kind) begin
        $error("token_kind: expected %0d, got %0d", want.token_kind, got.token_kind);
        mismatches++;
      end
      if (got.int_value !== want.int_value) begin
        $error("int_value: expected %0d, got %0d", want.int_value, got.int_value);
        mismatches++;
      end
      if (got.ident_len !== want.ident_len) begin
        $error("ident_len: expected %0d, got %0d", want.ident_len, got.ident_len);
        mismatches++;
      end
      if (got.char_value !== want.char_value) begin
        $error("char_value: expected 0x%02h, got 0x%02h", want.char_value, got.char_value);
        mismatches++;
      end
      if (got.line_number !== want.line_number) begin
        $error("line_number: expected %0d, got %0d", want.line_number, got.line_number);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        mismatches++;
      end
    end
  endfunction

  // Predict before comparing: a char item may be taken on the edge that takes its last token.
  always @(posedge clk) begin
    if (rst) begin
      mode = MD_IDLE;
      lit_acc = '0;
      id_len = 0;
      line_no = 24'd1;
      expected_tokens.delete();
    end else begin
      if (char_valid && !char_stall) predict_tokens(char_item);
      if (tok_valid && !tok_stall) check_token(tok_item);
    end
    waiting = expected_tokens.size();
  end

endmodule

// ----- bench/tb_small_language_lexer.sv -----
module tb_small_language_lexer import sll_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_ITEMS = 150;
  localparam int RANDOM_END  = 420;
  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 40;
  localparam int IDENT_BUF   = IDENT_BUF_DEF;

  typedef enum int {END_UNKNOWN, END_BANG, END_LONG} stream_end_t;

  logic     clk;
  logic     rst;
  logic     char_valid;
  logic     char_stall;
  sll_in_t  char_item;
  logic     tok_valid;
  logic     tok_stall = 1'b0;
  sll_out_t tok_item;

  int fail_count;
  int pending;
  int tokens_checked;

  int idle_pct = 22;
  int stall_pct = 74;
  int n_items = 0;
  int n_eoi = 0;
  int quiet_cycles = 0;
  bit last_word = 1'b0;

  small_language_lexer dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item),
    .tok_valid  (tok_valid),
    .tok_stall  (tok_stall),
    .tok_item   (tok_item)
  );

  sll_token_checker #(.IDENT_BUF(IDENT_BUF)) token_check (
    .clk            (clk),
    .rst            (rst),
    .char_valid     (char_valid),
    .char_stall     (char_stall),
    .char_item      (char_item),
    .tok_valid      (tok_valid),
    .tok_stall      (tok_stall),
    .tok_item       (tok_item),
    .fail_count     (fail_count),
    .pending        (pending),
    .tokens_checked (tokens_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    tok_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if ((char_valid && !char_stall) || (tok_valid && !tok_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic bit word_byte(logic [7:0] c);
    return (c >= "0" && c <= "9") || c == "_" || (c >= "a" && c <= "z") ||
           (c >= "A" && c <= "Z");
  endfunction

  function automatic bit lexable(logic [7:0] c);
    case (c)
      CH_SPACE, CH_TAB, CH_NL, CH_CR, CH_FF, "+", "-", "*", "/", ";", ":", "{", "}",
      "(", ")", "=", "<", ">", "!": return 1'b1;
      default: return word_byte(c);
    endcase
  endfunction

  function automatic string keyword_text(int k);
    case (k)
      0:       return "else";
      1:       return "for";
      2:       return "func";
      3:       return "if";
      4:       return "i32";
      5:       return "i64";
      6:       return "let";
      7:       return "print";
      8:       return "ret";
      9:       return "u0";
      10:      return "u8";
      default: return "while";
    endcase
  endfunction

  function automatic string op_text(int k);
    case (k)
      0:       return "+";
      1:       return "-";
      2:       return "*";
      3:       return "/";
      4:       return ";";
      5:       return ":";
      6:       return "{";
      7:       return "}";
      8:       return "(";
      9:       return ")";
      10:      return "=";
      11:      return "==";
      12:      return "<";
      13:      return "<=";
      14:      return ">";
      15:      return ">=";
      default: return "!=";
    endcase
  endfunction

  function automatic logic [7:0] rand_lead();
    int r;
    r = $urandom_range(52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] rand_word_ch();
    int r;
    r = $urandom_range(62);
    if (r < 52) return rand_lead();
    if (r < 62) return 8'("0" + r - 52);
    return "_";
  endfunction

  function automatic logic [7:0] blank_ch();
    case ($urandom_range(5))
      0, 1:    return CH_NL;
      2:       return CH_SPACE;
      3:       return CH_TAB;
      4:       return CH_CR;
      default: return CH_FF;
    endcase
  endfunction

  // Present one item, hold it until taken, then step the idle/stall phase.
  task automatic send_char(logic [7:0] c, logic eoi);
    while ($urandom_range(99) < idle_pct) begin
      char_valid <= 1'b0;
      @(negedge clk);
    end
    char_valid <= 1'b1;
    char_item <= '{char_code: c, end_of_input: eoi};
    do @(posedge clk); while (char_stall);
    n_items++;
    if (eoi) n_eoi++;
    last_word = !eoi && word_byte(c);
    if (n_items == PHASE_ITEMS) begin
      idle_pct = 74;
      stall_pct = 22;
    end else if (n_items == 2 * PHASE_ITEMS) begin
      idle_pct = 0;
      stall_pct = 0;
    end
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  // Keep words apart so that identifiers never grow past the buffer by accident.
  task automatic split_word();
    if (last_word) send_char(blank_ch(), 1'b0);
  endtask

  task automatic send_word();
    string kw;
    int    r;
    int    n;
    split_word();
    r = $urandom_range(9);
    kw = keyword_text($urandom_range(11));
    if (r < 3) begin
      send_text(kw);
    end else if (r == 3) begin
      send_text(kw.substr(0, kw.len() - 2));
    end else if (r == 4) begin
      send_text(kw);
      send_char(rand_word_ch(), 1'b0);
    end else begin
      n = (r == 9) ? $urandom_range(20, IDENT_BUF - 1) : $urandom_range(1, 6);
      send_char(rand_lead(), 1'b0);
      repeat (n - 1) send_char(rand_word_ch(), 1'b0);
    end
  endtask

  task automatic send_number();
    int r;
    split_word();
    r = $urandom_range(9);
    if (r == 0) begin
      send_text("2147483647");
    end else if (r == 1) begin
      send_text("2147483648");
    end else begin
      repeat (r == 2 ? $urandom_range(10, 12) : $urandom_range(1, 4))
        send_char(8'("0" + $urandom_range(9)), 1'b0);
    end
  endtask

  initial begin
    stream_end_t stream_end;
    logic [7:0]  c;
    int          r;

    rst = 1'b1;
    char_valid = 1'b0;
    char_item = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed: keyword, saturating literal, every paired operator, all blanks,
    // mixed-case name, and a pending '<' flushed by end of input.
    send_text("u8 9999999999");
    send_char(CH_TAB, 1'b0);
    send_text("<=_Az9>=");
    send_char(CH_CR, 1'b0);
    send_text("!=");
    send_char(CH_FF, 1'b0);
    send_text("==");
    send_char(CH_NL, 1'b0);
    send_text("<");
    send_char(8'($urandom_range(255)), 1'b1);

    while (n_items < RANDOM_END) begin
      r = $urandom_range(99);
      if (r < 30) send_word();
      else if (r < 45) send_number();
      else if (r < 78) send_text(op_text($urandom_range(16)));
      else if (r < 94) repeat ($urandom_range(1, 3)) send_char(blank_ch(), 1'b0);
      else send_char(8'($urandom_range(255)), 1'b1);
    end

    // Errors latch until reset, so exactly one closes the stream.
    stream_end = stream_end_t'($urandom_range(2));
    case (stream_end)
      END_UNKNOWN: begin
        do c = 8'($urandom_range(255)); while (lexable(c));
        send_char(c, 1'b0);
      end
      END_BANG: begin
        send_char("!", 1'b0);
        if ($urandom_range(1)) begin
          send_char(8'($urandom_range(255)), 1'b1);
        end else begin
          do c = 8'($urandom_range(255)); while (c == "=");
          send_char(c, 1'b0);
        end
      end
      default: begin
        split_word();
        send_char(rand_lead(), 1'b0);
        repeat (IDENT_BUF - 1) send_char(rand_word_ch(), 1'b0);
      end
    endcase

    // Anything after the error must be swallowed.
    repeat (20) send_char(8'($urandom_range(255)), $urandom_range(9) == 0);
    char_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("Lexed %0d items (%0d end-of-input marks) under three idle/stall phases,",
             n_items, n_eoi);
    $display("checked %0d tokens; stream closed by %s", tokens_checked, stream_end.name());
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
